### rtl/core/tcaf_pkg.sv
// Shared types, constants and helper functions for the tick count ASCII formatter.
// Used by every module of the block; depends on nothing else.
package tcaf_pkg;

    // Timing and conversion constants.
    localparam int unsigned TICKS_PER_SECOND = 100;
    localparam int unsigned SECS_PER_MINUTE  = 60;
    localparam int unsigned COUNT_W          = 32;
    localparam int unsigned BITS_PER_STEP    = 4;
    localparam int unsigned NIBBLES          = COUNT_W / BITS_PER_STEP;
    localparam int unsigned STEP_CNT_W       = $clog2(NIBBLES);
    localparam int unsigned TPS_W            = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned SEC_W            = $clog2(SECS_PER_MINUTE);
    localparam int unsigned FRAC_DIGITS      = 6;
    localparam int unsigned MIN_DIGITS       = 2;

    // Last conversion step counted while running (the first nibble is taken at load).
    localparam logic [STEP_CNT_W-1:0] RUN_LAST = STEP_CNT_W'(NIBBLES - 2);

    // Character positions within one run.
    localparam int unsigned CHAR_IDX_W = 3;
    localparam logic [CHAR_IDX_W-1:0] LAST_IDX = 3'd7;

    // Job queue geometry.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUIT  = 8'h71;

    typedef enum logic [1:0] {
        MODE_MINSEC = 2'd0,
        MODE_POINT  = 2'd1,
        MODE_PLAIN  = 2'd2
    } t_mode;

    // One classified request travelling from the front end to the converter.
    typedef struct packed {
        logic               quit;
        t_mode              mode;
        logic [COUNT_W-1:0] count;
    } t_job;

    // Running state of the serial conversion.
    typedef struct packed {
        logic [TPS_W-1:0]           rem_tick;
        logic [SEC_W-1:0]           rem_sec;
        logic [4*MIN_DIGITS-1:0]    bcd_min;
        logic [4*FRAC_DIGITS-1:0]   bcd_frac;
    } t_acc;

    // Finished conversion handed to the character emitter.
    typedef struct packed {
        logic                       quit;
        t_mode                      mode;
        logic [4*MIN_DIGITS-1:0]    bcd_min;
        logic [SEC_W-1:0]           sec;
        logic [4*FRAC_DIGITS-1:0]   bcd_frac;
    } t_conv;

    typedef struct packed {
        logic       last;
        logic [7:0] code;
    } t_char;

    // One shift-and-add-three step on six BCD digits; the top digit's carry is
    // dropped, which keeps the value modulo one million.
    function automatic logic [4*FRAC_DIGITS-1:0] dabble_frac(
        logic [4*FRAC_DIGITS-1:0] bcd, logic b);
        logic [4*FRAC_DIGITS-1:0] adj;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
        end
        return {adj[4*FRAC_DIGITS-2:0], b};
    endfunction

    // The same step on two digits, keeping the minutes modulo one hundred.
    function automatic logic [4*MIN_DIGITS-1:0] dabble_min(
        logic [4*MIN_DIGITS-1:0] bcd, logic b);
        logic [4*MIN_DIGITS-1:0] adj;
        for (int i = 0; i < MIN_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
        end
        return {adj[4*MIN_DIGITS-2:0], b};
    endfunction

    // One bit of the count: restoring division by the tick rate, whose quotient
    // bit feeds a restoring division by sixty, whose quotient bit feeds the
    // minutes digits. The raw bit also feeds the six-digit decimal form.
    function automatic t_acc acc_step(t_acc a, logic b);
        t_acc               r;
        logic [TPS_W:0]     t;
        logic               q_sec;
        logic [SEC_W:0]     u;
        logic               q_min;
        t     = {a.rem_tick, b};
        q_sec = (t >= (TPS_W+1)'(TICKS_PER_SECOND));
        r.rem_tick = q_sec ? TPS_W'(t - (TPS_W+1)'(TICKS_PER_SECOND)) : t[TPS_W-1:0];
        u     = {a.rem_sec, q_sec};
        q_min = (u >= (SEC_W+1)'(SECS_PER_MINUTE));
        r.rem_sec  = q_min ? SEC_W'(u - (SEC_W+1)'(SECS_PER_MINUTE)) : u[SEC_W-1:0];
        r.bcd_min  = dabble_min(a.bcd_min, q_min);
        r.bcd_frac = dabble_frac(a.bcd_frac, b);
        return r;
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] d);
        return CH_ZERO + {4'd0, d};
    endfunction

    // Splits seconds below sixty into tens and units digits.
    function automatic logic [7:0] sec_split(logic [SEC_W-1:0] s);
        logic [3:0]       tens;
        logic [SEC_W-1:0] units;
        if (s >= SEC_W'(50))      tens = 4'd5;
        else if (s >= SEC_W'(40)) tens = 4'd4;
        else if (s >= SEC_W'(30)) tens = 4'd3;
        else if (s >= SEC_W'(20)) tens = 4'd2;
        else if (s >= SEC_W'(10)) tens = 4'd1;
        else                      tens = 4'd0;
        units = s - SEC_W'(tens) * SEC_W'(10);
        return {tens, units[3:0]};
    endfunction

    // Character at a given position of a run.
    function automatic t_char char_at(t_conv c, logic [CHAR_IDX_W-1:0] idx);
        t_char      r;
        logic [7:0] s;
        s      = sec_split(c.sec);
        r.last = (idx == LAST_IDX);
        r.code = CH_CR;
        if (c.quit) begin
            r.last = 1'b1;
        end else begin
            case (c.mode)
                MODE_POINT: begin
                    case (idx)
                        3'd1:    r.code = digit_char(c.bcd_frac[23:20]);
                        3'd2:    r.code = digit_char(c.bcd_frac[19:16]);
                        3'd3:    r.code = digit_char(c.bcd_frac[15:12]);
                        3'd4:    r.code = digit_char(c.bcd_frac[11:8]);
                        3'd5:    r.code = CH_POINT;
                        3'd6:    r.code = digit_char(c.bcd_frac[7:4]);
                        3'd7:    r.code = digit_char(c.bcd_frac[3:0]);
                        default: r.code = CH_CR;
                    endcase
                end
                MODE_PLAIN: begin
                    case (idx)
                        3'd1:    r.code = digit_char(c.bcd_frac[23:20]);
                        3'd2:    r.code = digit_char(c.bcd_frac[19:16]);
                        3'd3:    r.code = digit_char(c.bcd_frac[15:12]);
                        3'd4:    r.code = digit_char(c.bcd_frac[11:8]);
                        3'd5:    r.code = digit_char(c.bcd_frac[7:4]);
                        3'd6:    r.code = digit_char(c.bcd_frac[3:0]);
                        3'd7:    r.code = CH_SPACE;
                        default: r.code = CH_CR;
                    endcase
                end
                default: begin
                    case (idx)
                        3'd1:    r.code = digit_char(c.bcd_min[7:4]);
                        3'd2:    r.code = digit_char(c.bcd_min[3:0]);
                        3'd3:    r.code = CH_COLON;
                        3'd4:    r.code = digit_char(s[7:4]);
                        3'd5:    r.code = digit_char(s[3:0]);
                        3'd6:    r.code = CH_SPACE;
                        3'd7:    r.code = CH_SPACE;
                        default: r.code = CH_CR;
                    endcase
                end
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/core/tick_count_ascii_formatter.sv
// Top level of the tick count ASCII formatter: front end, job queue, converter, emitter.
// Depends on tcaf_pkg, tcaf_front, tcaf_queue, tcaf_convert and tcaf_emit.
//
// Usage: requests enter through a queue-like port (push/full) with an optional
// received byte and the current tick count. Characters leave through a second
// queue-like port (empty/pop), one character per request, last_char marking
// the final character of each run. A running request gives eight characters:
// a carriage return and the count in the held mode. A 'q' byte gives a single
// carriage return and stops all later output; requests are still taken.
// The converter consumes four bits of the 32-bit count per cycle, and the output
// register sends one character per cycle while the receiver keeps popping.
// A two-entry job queue lets requests be taken while a run is still draining.
// Reset clears the mode to minutes and seconds and releases the halt.
// When the receiver stalls, the output character holds, the converter keeps its
// finished result and the queue fills; full rises once it holds two jobs.
module tick_count_ascii_formatter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_byte_valid,
    input  logic [7:0]                    i_rx_byte,
    input  logic [tcaf_pkg::COUNT_W-1:0]  i_tick_count,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_char_code,
    output logic                          o_last_char
);
    import tcaf_pkg::*;

    logic  q_wr, q_wr_ready;
    t_job  q_wr_data;
    logic  job_valid, job_take;
    t_job  job_data;
    logic  conv_valid, conv_take;
    t_conv conv_data;

    // Request classification.
    tcaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_byte_valid (i_byte_valid),
        .i_rx_byte    (i_rx_byte),
        .i_tick_count (i_tick_count),
        .o_job_valid  (q_wr),
        .o_job        (q_wr_data),
        .i_job_ready  (q_wr_ready)
    );

    // Decoupling queue.
    tcaf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_wr_data  (q_wr_data),
        .o_wr_ready (q_wr_ready),
        .o_rd_valid (job_valid),
        .o_rd_data  (job_data),
        .i_rd       (job_take)
    );

    // Decimal conversion.
    tcaf_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job_data),
        .o_job_take   (job_take),
        .o_conv_valid (conv_valid),
        .o_conv       (conv_data),
        .i_conv_take  (conv_take)
    );

    // Character output.
    tcaf_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv_valid (conv_valid),
        .i_conv       (conv_data),
        .o_conv_take  (conv_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

`ifndef ASSERT_OFF
    // A finished conversion stays put until the emitter takes it.
    a_conv_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_valid && !conv_take |=> conv_valid && $stable(conv_data))
        else $error("converter result changed before it was taken");

    // A queued job stays at the head until the converter takes it.
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && !job_take |=> job_valid && $stable(job_data))
        else $error("queue head changed before it was taken");

    // Once a quit job is written, the front end writes nothing more.
    a_quit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr && q_wr_data.quit |=> !q_wr)
        else $error("job written after quit");
`endif

endmodule

### rtl/core/tcaf_front.sv
// Front end of the formatter: accepts input requests, tracks mode and halt state.
// Depends on tcaf_pkg.
module tcaf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_byte_valid,
    input  logic [7:0]                    i_rx_byte,
    input  logic [tcaf_pkg::COUNT_W-1:0]  i_tick_count,
    output logic                          o_job_valid,
    output tcaf_pkg::t_job                o_job,
    input  logic                          i_job_ready
);
    import tcaf_pkg::*;

    t_mode r_mode, n_mode;
    logic  r_halted, n_halted;
    logic  accept;

    // The front end is full exactly when the job queue is.
    assign o_full = !i_job_ready;
    assign accept = i_push && i_job_ready;

    // Classify the received byte once and form the job.
    always_comb begin
        n_mode      = r_mode;
        n_halted    = r_halted;
        o_job_valid = 1'b0;
        o_job.quit  = 1'b0;
        if (accept && !r_halted) begin
            o_job_valid = 1'b1;
            if (i_byte_valid) begin
                case (i_rx_byte)
                    CH_ONE:   n_mode = MODE_MINSEC;
                    CH_TWO:   n_mode = MODE_POINT;
                    CH_THREE: n_mode = MODE_PLAIN;
                    CH_QUIT: begin
                        o_job.quit = 1'b1;
                        n_halted   = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        o_job.mode  = n_mode;
        o_job.count = i_tick_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MINSEC;
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_halted <= n_halted;
        end
    end

endmodule

### rtl/core/tcaf_queue.sv
// Short job queue between the front end and the converter.
// Depends on tcaf_pkg.
module tcaf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  tcaf_pkg::t_job i_wr_data,
    output logic           o_wr_ready,
    output logic           o_rd_valid,
    output tcaf_pkg::t_job o_rd_data,
    input  logic           i_rd
);
    import tcaf_pkg::*;

    t_job               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QFILL_W-1:0] r_fill, n_fill;
    logic               wr_en, rd_en;

    assign o_wr_ready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_fill != '0);
    assign o_rd_data  = r_slot[r_rd_ptr];
    assign wr_en      = i_wr && o_wr_ready;
    assign rd_en      = i_rd && o_rd_valid;

    // Occupancy follows the two request strobes.
    always_comb begin
        n_fill = r_fill;
        if (wr_en && !rd_en) begin
            n_fill = r_fill + QFILL_W'(1);
        end else if (rd_en && !wr_en) begin
            n_fill = r_fill - QFILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // Storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/core/tcaf_convert.sv
// Serial converter: turns a tick count into decimal digits, four bits a cycle.
// Depends on tcaf_pkg.
module tcaf_convert (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  tcaf_pkg::t_job  i_job,
    output logic            o_job_take,
    output logic            o_conv_valid,
    output tcaf_pkg::t_conv o_conv,
    input  logic            i_conv_take
);
    import tcaf_pkg::*;

    typedef enum logic [2:0] {
        CS_EMPTY = 3'b001,
        CS_RUN   = 3'b010,
        CS_DONE  = 3'b100
    } t_conv_state;

    t_conv_state             r_state, n_state;
    logic [STEP_CNT_W-1:0]   r_cnt;
    logic [COUNT_W-1:0]      r_shift;
    t_acc                    r_acc, acc_in, acc_out;
    logic                    r_quit;
    t_mode                   r_mode;
    logic [BITS_PER_STEP-1:0] bits;
    logic                    load;

    // A new job enters when the unit is empty or its result leaves this cycle.
    assign load = i_job_valid
               && ((r_state == CS_EMPTY) || ((r_state == CS_DONE) && i_conv_take));
    assign o_job_take = load;

    // Four bits of the count per cycle; the first nibble is taken at load.
    always_comb begin
        acc_in  = load ? '0 : r_acc;
        bits    = load ? i_job.count[COUNT_W-1 -: BITS_PER_STEP]
                       : r_shift[COUNT_W-1 -: BITS_PER_STEP];
        acc_out = acc_in;
        for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
            acc_out = acc_step(acc_out, bits[k]);
        end
    end

    // Sequencing of one job.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_EMPTY: begin
                if (load) begin
                    n_state = i_job.quit ? CS_DONE : CS_RUN;
                end
            end
            CS_RUN: begin
                if (r_cnt == RUN_LAST) begin
                    n_state = CS_DONE;
                end
            end
            CS_DONE: begin
                if (load) begin
                    n_state = i_job.quit ? CS_DONE : CS_RUN;
                end else if (i_conv_take) begin
                    n_state = CS_EMPTY;
                end
            end
            default: n_state = CS_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_EMPTY;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_cnt <= '0;
            end else if (r_state == CS_RUN) begin
                r_cnt <= r_cnt + STEP_CNT_W'(1);
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (load || (r_state == CS_RUN)) begin
            r_acc   <= acc_out;
            r_shift <= (load ? i_job.count : r_shift) << BITS_PER_STEP;
        end
        if (load) begin
            r_quit <= i_job.quit;
            r_mode <= i_job.mode;
        end
    end

    assign o_conv_valid    = (r_state == CS_DONE);
    assign o_conv.quit     = r_quit;
    assign o_conv.mode     = r_mode;
    assign o_conv.bcd_min  = r_acc.bcd_min;
    assign o_conv.sec      = r_acc.rem_sec;
    assign o_conv.bcd_frac = r_acc.bcd_frac;

endmodule

### rtl/core/tcaf_emit.sv
// Character emitter: walks a converted result and drives the output register.
// Depends on tcaf_pkg.
module tcaf_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_conv_valid,
    input  tcaf_pkg::t_conv i_conv,
    output logic            o_conv_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_char_code,
    output logic            o_last_char
);
    import tcaf_pkg::*;

    t_conv                  r_res;
    logic [CHAR_IDX_W-1:0]  r_idx;
    logic                   r_active;
    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    t_char                  cur;
    logic                   free;
    logic                   take;

    assign cur  = char_at(r_res, r_idx);
    assign free = !r_out_valid || i_pop;
    // The next result is taken when idle or as the last character of the current run is registered.
    assign take = free && i_conv_valid && (!r_active || cur.last);
    assign o_conv_take = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (free) begin
                r_out_valid <= r_active;
            end
            if (take) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (free && r_active) begin
                if (cur.last) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + CHAR_IDX_W'(1);
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= i_conv;
        end
        if (free && r_active) begin
            r_char <= cur.code;
            r_last <= cur.last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule
